### sv/rrst_pkg.sv
// Shared types and constants of the resource slot table.
package rrst_pkg;

  localparam int unsigned SlotsDefault = 8;
  localparam int unsigned RefsDefault  = 9;

  localparam int unsigned CmdW      = 3;
  localparam int unsigned TypeW     = 15;
  localparam int unsigned SlotTypeW = 16;
  localparam int unsigned NameW     = 16;
  localparam int unsigned PosW      = 32;
  localparam int unsigned CountW    = 4;
  localparam int unsigned IdxW      = 3;
  localparam int unsigned MaskW     = 8;

  localparam logic [SlotTypeW-1:0] EmptyType = '1;
  localparam logic [CountW-1:0]    CountMax  = '1;

  typedef enum logic [CmdW-1:0] {
    CMD_ACQUIRE   = 3'd0,
    CMD_RELEASE   = 3'd1,
    CMD_LOOKUP    = 3'd2,
    CMD_SWEEP     = 3'd3,
    CMD_LOAD_TICK = 3'd4
  } cmd_e;

  typedef enum logic [5:0] {
    ST_CLEAR    = 6'b000001,
    ST_IDLE     = 6'b000010,
    ST_DISPATCH = 6'b000100,
    ST_SCAN     = 6'b001000,
    ST_COMMIT   = 6'b010000,
    ST_OUT      = 6'b100000
  } state_e;

  typedef struct packed {
    logic [NameW-1:0] name;
    logic [PosW-1:0]  pos_x;
    logic [PosW-1:0]  pos_z;
  } key_t;

endpackage

### sv/refcounted_resource_slot_table_unit.sv
// Top level of the reference-counted resource slot table.
//
// Usage:
// - Input channel (in_valid_i / in_stall_o): one beat carries a command, a
//   type code and a reference key (name, x and z position words). A beat is
//   taken only while the sequencer is idle; one command is worked at a time.
// - Output channel (out_valid_o / out_stall_i): exactly one result beat per
//   command. The result sits in an output register, so the next command is
//   accepted while a result still waits; a finished command holds in the
//   output state until that register frees up.
// - Configuration: cfg_we_i writes cfg_wdata_i into bank_ready; write it only
//   while no command is in flight.
// - Sequence: lookup, sweep, load tick and commands that find no slot go from
//   dispatch straight to the output state; acquire and release first read
//   the slot's Refs keys one per cycle from the key memory (one read port,
//   registered read) in the scan state, then write back in the commit state.
// - Reset: slot types go empty, counts, pending marks and dirty clear, then
//   a clearing pass writes every key entry to zero, one entry per cycle,
//   all Slots * Refs entries (72 at the default). No command is accepted during
//   that pass; configuration writes are taken as usual.
// - Slot flags live in flops and are searched in parallel; keys live in the
//   memory and are read, modified and written back by the sequencer.
module refcounted_resource_slot_table_unit #(
  parameter int unsigned Slots = rrst_pkg::SlotsDefault,
  parameter int unsigned Refs  = rrst_pkg::RefsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  // command beat
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [rrst_pkg::CmdW-1:0]     command_i,
  input  logic [rrst_pkg::TypeW-1:0]    type_code_i,
  input  logic [rrst_pkg::NameW-1:0]    ref_name_i,
  input  logic [rrst_pkg::PosW-1:0]     pos_x_bits_i,
  input  logic [rrst_pkg::PosW-1:0]     pos_z_bits_i,
  // result beat
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          found_o,
  output logic [rrst_pkg::IdxW-1:0]     slot_index_o,
  output logic [rrst_pkg::CountW-1:0]   ref_count_o,
  output logic [rrst_pkg::MaskW-1:0]    loaded_mask_o
);
  import rrst_pkg::*;

  localparam int unsigned Depth = Slots * Refs;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned SW    = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned KW    = (Refs > 1) ? $clog2(Refs) : 1;
  localparam int unsigned KCW   = $clog2(Refs + 1);

  // ---------------------------------------------------------------- state
  state_e state_q, state_d;

  logic                 bank_ready_q;
  logic [SlotTypeW-1:0] slot_type_q  [Slots];
  logic [SlotTypeW-1:0] slot_type_d  [Slots];
  logic [CountW-1:0]    slot_count_q [Slots];
  logic [CountW-1:0]    slot_count_d [Slots];
  logic [Slots-1:0]     slot_pending_q, slot_pending_d;
  logic                 dirty_q, dirty_d;

  logic [AW-1:0]        clr_addr_q, clr_addr_d;

  // latched command
  logic [CmdW-1:0]      cmd_q;
  logic [TypeW-1:0]     type_q;
  logic [NameW-1:0]     name_q;
  logic [PosW-1:0]      x_q;
  logic [PosW-1:0]      z_q;

  // working slot and key scan
  logic [SW-1:0]        slot_q, slot_d;
  logic                 join_q, join_d;
  logic [KCW-1:0]       scan_k_q, scan_k_d;
  logic                 rd_vld_q;
  logic [KW-1:0]        rd_k_q;
  logic                 match_hit_q, match_hit_d;
  logic [KW-1:0]        match_k_q, match_k_d;
  logic                 free_hit_q, free_hit_d;
  logic [KW-1:0]        free_k_q, free_k_d;

  // finished result, then output register
  logic                 res_found_q, res_found_d;
  logic [IdxW-1:0]      res_slot_q, res_slot_d;
  logic [CountW-1:0]    res_count_q, res_count_d;
  logic [MaskW-1:0]     res_mask_q, res_mask_d;
  logic                 out_valid_q;
  logic                 out_load;

  // key memory
  key_t                 key_mem [Depth];
  key_t                 key_rd_q;
  logic                 key_we;
  logic [AW-1:0]        key_waddr;
  key_t                 key_wdata;
  logic                 rd_en;
  logic [AW-1:0]        key_base;
  logic [AW-1:0]        key_raddr;

  logic in_accept;
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);

  // ------------------------------------------------------ slot searches
  logic [SlotTypeW-1:0] type_ext;
  logic          type_hit, empty_hit, zero_hit, look_hit;
  logic [SW-1:0] type_idx, empty_idx, zero_idx, look_idx;
  logic [Slots-1:0] swept_pending;

  assign type_ext = {1'b0, type_q};

  // downward loop leaves the lowest matching slot
  always_comb begin
    type_hit  = 1'b0;
    empty_hit = 1'b0;
    zero_hit  = 1'b0;
    look_hit  = 1'b0;
    type_idx  = '0;
    empty_idx = '0;
    zero_idx  = '0;
    look_idx  = '0;
    for (int s = Slots - 1; s >= 0; s--) begin
      if (slot_type_q[s] == type_ext) begin
        type_hit = 1'b1;
        type_idx = SW'(s);
      end
      if (slot_type_q[s] == EmptyType) begin
        empty_hit = 1'b1;
        empty_idx = SW'(s);
      end
      if (slot_count_q[s] == '0) begin
        zero_hit = 1'b1;
        zero_idx = SW'(s);
      end
      if ((slot_type_q[s] == type_ext) && !slot_pending_q[s]) begin
        look_hit = 1'b1;
        look_idx = SW'(s);
      end
    end
  end

  // ------------------------------------------------ key memory addressing
  logic [KW-1:0] wr_k;

  assign key_base  = AW'(AW'(slot_q) * AW'(Refs));
  assign rd_en     = (state_q == ST_SCAN) && (scan_k_q < KCW'(Refs));
  assign key_raddr = key_base + AW'(scan_k_q[KW-1:0]);

  // ---------------------------------------------------------- sequencer
  logic [CountW-1:0] cur_count;
  logic              rd_match, rd_free;

  assign cur_count = slot_count_q[slot_q];
  assign rd_match  = (key_rd_q.name == name_q) && (key_rd_q.pos_x == x_q) &&
                     (key_rd_q.pos_z == z_q);
  assign rd_free   = (key_rd_q.name == '0);

  always_comb begin
    state_d        = state_q;
    slot_type_d    = slot_type_q;
    slot_count_d   = slot_count_q;
    slot_pending_d = slot_pending_q;
    dirty_d        = dirty_q;
    clr_addr_d     = clr_addr_q;
    slot_d         = slot_q;
    join_d         = join_q;
    scan_k_d       = scan_k_q;
    match_hit_d    = match_hit_q;
    match_k_d      = match_k_q;
    free_hit_d     = free_hit_q;
    free_k_d       = free_k_q;
    res_found_d    = res_found_q;
    res_slot_d     = res_slot_q;
    res_count_d    = res_count_q;
    res_mask_d     = res_mask_q;
    key_we         = 1'b0;
    wr_k           = '0;
    key_waddr      = key_base;
    key_wdata      = '0;
    swept_pending  = '0;

    case (state_q)
      ST_CLEAR: begin
        key_we     = 1'b1;
        key_waddr  = clr_addr_q;
        clr_addr_d = clr_addr_q + AW'(1);
        if (clr_addr_q == AW'(Depth - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_DISPATCH;
        end
      end

      ST_DISPATCH: begin
        state_d     = ST_OUT;
        res_found_d = 1'b0;
        res_slot_d  = '0;
        res_count_d = '0;
        res_mask_d  = '0;
        match_hit_d = 1'b0;
        free_hit_d  = 1'b0;
        match_k_d   = '0;
        free_k_d    = '0;
        scan_k_d    = '0;
        case (cmd_q)
          CMD_ACQUIRE: begin
            if (type_hit) begin
              slot_d  = type_idx;
              join_d  = 1'b1;
              state_d = ST_SCAN;
            end else if (empty_hit) begin
              slot_d  = empty_idx;
              join_d  = 1'b0;
              state_d = ST_SCAN;
            end else if (zero_hit) begin
              slot_d  = zero_idx;
              join_d  = 1'b0;
              state_d = ST_SCAN;
            end
          end
          CMD_RELEASE: begin
            if (type_hit) begin
              slot_d = type_idx;
              if (slot_count_q[type_idx] != '0) begin
                state_d = ST_SCAN;
              end else begin
                // slot known but holds no reference
                res_slot_d = IdxW'(type_idx);
              end
            end
          end
          CMD_LOOKUP: begin
            if (look_hit) begin
              res_found_d = 1'b1;
              res_slot_d  = IdxW'(look_idx);
              res_count_d = slot_count_q[look_idx];
            end
          end
          CMD_SWEEP: begin
            for (int s = 0; s < Slots; s++) begin
              if ((slot_type_q[s] == EmptyType) || (slot_count_q[s] == '0)) begin
                slot_type_d[s]   = EmptyType;
                slot_count_d[s]  = '0;
                swept_pending[s] = 1'b0;
              end else begin
                swept_pending[s] = 1'b1;
              end
            end
            // the table is dirty now, so the load runs on bank_ready alone
            if (bank_ready_q) begin
              res_mask_d     = MaskW'(swept_pending);
              slot_pending_d = '0;
              dirty_d        = 1'b0;
            end else begin
              slot_pending_d = swept_pending;
              dirty_d        = 1'b1;
            end
          end
          CMD_LOAD_TICK: begin
            if (bank_ready_q && dirty_q) begin
              res_mask_d     = MaskW'(slot_pending_q);
              slot_pending_d = '0;
              dirty_d        = 1'b0;
            end
          end
          default: ;
        endcase
      end

      ST_SCAN: begin
        if (scan_k_q < KCW'(Refs)) begin
          scan_k_d = scan_k_q + KCW'(1);
        end
        if (rd_vld_q) begin
          if (rd_match && !match_hit_q) begin
            match_hit_d = 1'b1;
            match_k_d   = rd_k_q;
          end
          if (rd_free && !free_hit_q) begin
            free_hit_d = 1'b1;
            free_k_d   = rd_k_q;
          end
          if (rd_k_q == KW'(Refs - 1)) begin
            state_d = ST_COMMIT;
          end
        end
      end

      ST_COMMIT: begin
        state_d     = ST_OUT;
        res_found_d = 1'b0;
        res_slot_d  = IdxW'(slot_q);
        res_count_d = cur_count;
        res_mask_d  = '0;
        if (cmd_q == CMD_ACQUIRE) begin
          if (join_q && match_hit_q) begin
            res_found_d = 1'b1;
          end else if (free_hit_q) begin
            key_we          = 1'b1;
            wr_k            = free_k_q;
            key_waddr       = key_base + AW'(wr_k);
            key_wdata.name  = name_q;
            key_wdata.pos_x = x_q;
            key_wdata.pos_z = z_q;
            res_found_d     = 1'b1;
            if (join_q) begin
              if (cur_count != CountMax) begin
                slot_count_d[slot_q] = cur_count + CountW'(1);
                res_count_d          = cur_count + CountW'(1);
              end
            end else begin
              // fresh allocation: old keys of a reused slot stay put
              slot_type_d[slot_q]    = type_ext;
              slot_count_d[slot_q]   = CountW'(1);
              slot_pending_d[slot_q] = 1'b1;
              dirty_d                = 1'b1;
              res_count_d            = CountW'(1);
            end
          end
        end else if (match_hit_q) begin
          // release: key goes back to all zero
          key_we               = 1'b1;
          wr_k                 = match_k_q;
          key_waddr            = key_base + AW'(wr_k);
          slot_count_d[slot_q] = cur_count - CountW'(1);
          res_count_d          = cur_count - CountW'(1);
          res_found_d          = 1'b1;
        end
      end

      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // ------------------------------------------------------- control regs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_CLEAR;
      bank_ready_q   <= 1'b0;
      slot_pending_q <= '0;
      dirty_q        <= 1'b0;
      clr_addr_q     <= '0;
      scan_k_q       <= '0;
      rd_vld_q       <= 1'b0;
      out_valid_q    <= 1'b0;
      for (int s = 0; s < Slots; s++) begin
        slot_type_q[s]  <= EmptyType;
        slot_count_q[s] <= '0;
      end
    end else begin
      state_q        <= state_d;
      slot_type_q    <= slot_type_d;
      slot_count_q   <= slot_count_d;
      slot_pending_q <= slot_pending_d;
      dirty_q        <= dirty_d;
      clr_addr_q     <= clr_addr_d;
      scan_k_q       <= scan_k_d;
      rd_vld_q       <= rd_en;
      if (cfg_we_i) begin
        bank_ready_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------- datapath regs
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q  <= command_i;
      type_q <= type_code_i;
      name_q <= ref_name_i;
      x_q    <= pos_x_bits_i;
      z_q    <= pos_z_bits_i;
    end
    slot_q      <= slot_d;
    join_q      <= join_d;
    rd_k_q      <= scan_k_q[KW-1:0];
    match_hit_q <= match_hit_d;
    match_k_q   <= match_k_d;
    free_hit_q  <= free_hit_d;
    free_k_q    <= free_k_d;
    res_found_q <= res_found_d;
    res_slot_q  <= res_slot_d;
    res_count_q <= res_count_d;
    res_mask_q  <= res_mask_d;
    if (out_load) begin
      found_o       <= res_found_q;
      slot_index_o  <= res_slot_q;
      ref_count_o   <= res_count_q;
      loaded_mask_o <= res_mask_q;
    end
  end

  // ---------------------------------------------------------- key memory
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[key_waddr] <= key_wdata;
    end
    if (rd_en) begin
      key_rd_q <= key_mem[key_raddr];
    end
  end

  assign out_valid_o = out_valid_q;

  // ---------------------------------------------------------- assertions
  a_no_write_during_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> !key_we)
    else $error("key memory written while keys are being read");

  a_commit_after_last_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COMMIT) |-> ($past(rd_vld_q) && ($past(rd_k_q) == KW'(Refs - 1))))
    else $error("commit without the last key beat");

  a_sweep_loads_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DISPATCH) && (cmd_q == CMD_SWEEP) && bank_ready_q)
      |=> ((slot_pending_q == '0) && !dirty_q))
    else $error("sweep with bank ready left pending slots");

  a_result_from_out_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_OUT))
    else $error("result beat raised outside the output state");

  a_no_accept_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> in_stall_o)
    else $error("command taken during key clearing pass");

endmodule
